[hdl/rgb_to_hsv_converter_defines.svh]
// assertion macros for the rgb to hsv converter checker
// no dependencies; included by the checker file only
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RGBHSV_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rgb_to_hsv_converter check failed");

// next-cycle implication, checked outside reset
`define RGBHSV_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rgb_to_hsv_converter check failed");

`endif

[hdl/rgbhsv_pkg.sv]
// shared types and constants for the rgb to hsv converter
// no dependencies
`default_nettype none

package rgbhsv_pkg;

   localparam int PIXEL_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int HUE_W      = 15;
   localparam int SAT_W      = 8;
   localparam int SECTOR_DEG = 60;

   // 60 degree hue sectors, code times 60 is the sector base in degrees
   typedef enum logic [2:0] {
      SECTOR_RED_YEL = 3'd0,
      SECTOR_YEL_GRN = 3'd1,
      SECTOR_GRN_CYN = 3'd2,
      SECTOR_CYN_BLU = 3'd3,
      SECTOR_BLU_MAG = 3'd4,
      SECTOR_MAG_RED = 3'd5
   } hue_sector_type;

   // per-pixel side information carried along the pipeline
   typedef struct packed {
      hue_sector_type     sector;
      logic               grey;
      logic               black;
      logic [CHAN_W-1:0]  brightness;
   } pix_info_type;

endpackage

`default_nettype wire

[hdl/rgbhsv_front.sv]
// front end: channel max/min, hue sector and the two divider operands
// depends on rgbhsv_pkg
`default_nettype none

module rgbhsv_front #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int QUO_W         = 12
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire logic                                           in_valid,
   output logic                                                in_ready,
   input  wire logic [rgbhsv_pkg::PIXEL_W-1:0]                 in_pixel,
   output logic                                                out_valid,
   input  wire logic                                           out_ready,
   output logic [rgbhsv_pkg::CHAN_W+QUO_W-1:0]                 out_hue_acc,
   output logic [rgbhsv_pkg::CHAN_W+QUO_W-1:0]                 out_sat_acc,
   output logic [rgbhsv_pkg::CHAN_W-1:0]                       out_hue_div,
   output logic [rgbhsv_pkg::CHAN_W-1:0]                       out_sat_div,
   output rgbhsv_pkg::pix_info_type                            out_info
);
   import rgbhsv_pkg::*;

   localparam int ACC_W = CHAN_W + QUO_W;

   logic               s1_valid_ff;
   logic [CHAN_W-1:0]  s1_x_ff, s1_x_in;
   logic [CHAN_W-1:0]  s1_delta_ff, s1_delta_in;
   pix_info_type       s1_info_ff, s1_info_in;

   logic               s2_valid_ff;
   logic [ACC_W-1:0]   s2_hue_acc_ff, s2_hue_acc_in;
   logic [ACC_W-1:0]   s2_sat_acc_ff, s2_sat_acc_in;
   logic [CHAN_W-1:0]  s2_delta_ff;
   pix_info_type       s2_info_ff;

   logic               s1_en, s2_en;

   assign s2_en    = !s2_valid_ff || out_ready;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;

   // stage 1: max with red then green winning ties, sector and offset within it
   always_comb begin
      logic [CHAN_W-1:0] r, g, b, mx, mn;
      r = in_pixel[23:16];
      g = in_pixel[15:8];
      b = in_pixel[7:0];
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      if (r >= g && r >= b) begin
         mx = r;
      end else if (g >= b) begin
         mx = g;
      end else begin
         mx = b;
      end
      s1_delta_in = mx - mn;
      if (r >= g && r >= b) begin
         if (g >= b) begin
            s1_info_in.sector = SECTOR_RED_YEL;
            s1_x_in           = g - b;
         end else begin
            s1_info_in.sector = SECTOR_MAG_RED;
            s1_x_in           = s1_delta_in - (b - g);
         end
      end else if (g >= b) begin
         if (b >= r) begin
            s1_info_in.sector = SECTOR_GRN_CYN;
            s1_x_in           = b - r;
         end else begin
            s1_info_in.sector = SECTOR_YEL_GRN;
            s1_x_in           = s1_delta_in - (r - b);
         end
      end else begin
         if (r >= g) begin
            s1_info_in.sector = SECTOR_BLU_MAG;
            s1_x_in           = r - g;
         end else begin
            s1_info_in.sector = SECTOR_CYN_BLU;
            s1_x_in           = s1_delta_in - (g - r);
         end
      end
      s1_info_in.grey       = (s1_delta_in == '0);
      s1_info_in.black      = (mx == '0);
      s1_info_in.brightness = mx;
   end

   // stage 2: hue numerator 60*x scaled by the fraction bits, saturation numerator 255*delta
   always_comb begin
      logic [CHAN_W+5:0] x60;
      x60 = {s1_x_ff, 6'd0} - {4'd0, s1_x_ff, 2'd0};
      s2_hue_acc_in = ACC_W'(x60) << HUE_FRAC_BITS;
      s2_sat_acc_in = ACC_W'({s1_delta_ff, 8'd0} - {8'd0, s1_delta_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= in_valid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_x_ff     <= s1_x_in;
         s1_delta_ff <= s1_delta_in;
         s1_info_ff  <= s1_info_in;
      end
      if (s2_en) begin
         s2_hue_acc_ff <= s2_hue_acc_in;
         s2_sat_acc_ff <= s2_sat_acc_in;
         s2_delta_ff   <= s1_delta_ff;
         s2_info_ff    <= s1_info_ff;
      end
   end

   assign out_valid   = s2_valid_ff;
   assign out_hue_acc = s2_hue_acc_ff;
   assign out_sat_acc = s2_sat_acc_ff;
   assign out_hue_div = s2_delta_ff;
   assign out_sat_div = s2_info_ff.brightness;
   assign out_info    = s2_info_ff;

endmodule

`default_nettype wire

[hdl/rgbhsv_divider.sv]
// pipelined restoring divider, two lanes (hue and saturation), one quotient bit per stage
// depends on rgbhsv_pkg
`default_nettype none

module rgbhsv_divider #(
   parameter int QUO_W = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic [rgbhsv_pkg::CHAN_W+QUO_W-1:0] in_hue_acc,
   input  wire logic [rgbhsv_pkg::CHAN_W+QUO_W-1:0] in_sat_acc,
   input  wire logic [rgbhsv_pkg::CHAN_W-1:0]       in_hue_div,
   input  wire logic [rgbhsv_pkg::CHAN_W-1:0]       in_sat_div,
   input  wire rgbhsv_pkg::pix_info_type            in_info,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic [QUO_W-1:0]                         out_hue_quo,
   output logic [QUO_W-1:0]                         out_sat_quo,
   output rgbhsv_pkg::pix_info_type                 out_info
);
   import rgbhsv_pkg::*;

   localparam int ACC_W = CHAN_W + QUO_W;

   // acc holds {partial remainder, unconsumed dividend bits / quotient bits so far}
   function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                  input logic [CHAN_W-1:0] d);
      logic [CHAN_W:0] trial;
      logic [CHAN_W:0] diff;
      trial = acc[ACC_W-1 -: CHAN_W+1];
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         return {diff[CHAN_W-1:0], acc[QUO_W-2:0], 1'b1};
      end else begin
         return {trial[CHAN_W-1:0], acc[QUO_W-2:0], 1'b0};
      end
   endfunction

   logic               valid_q   [QUO_W+1];
   logic               en        [QUO_W+1];
   logic [ACC_W-1:0]   hue_acc_q [QUO_W+1];
   logic [ACC_W-1:0]   sat_acc_q [QUO_W+1];
   logic [CHAN_W-1:0]  hue_div_q [QUO_W+1];
   logic [CHAN_W-1:0]  sat_div_q [QUO_W+1];
   pix_info_type       info_q    [QUO_W+1];

   assign valid_q[0]   = in_valid;
   assign hue_acc_q[0] = in_hue_acc;
   assign sat_acc_q[0] = in_sat_acc;
   assign hue_div_q[0] = in_hue_div;
   assign sat_div_q[0] = in_sat_div;
   assign info_q[0]    = in_info;
   assign en[QUO_W]    = out_ready;
   assign in_ready     = en[0];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic               valid_ff;
      logic [ACC_W-1:0]   hue_acc_ff, hue_acc_in;
      logic [ACC_W-1:0]   sat_acc_ff, sat_acc_in;
      logic [CHAN_W-1:0]  hue_div_ff;
      logic [CHAN_W-1:0]  sat_div_ff;
      pix_info_type       info_ff;

      // a stage moves when it is empty or the stage after it moves
      assign en[k] = !valid_ff || en[k+1];

      assign hue_acc_in = div_step(hue_acc_q[k], hue_div_q[k]);
      assign sat_acc_in = div_step(sat_acc_q[k], sat_div_q[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en[k]) begin
            valid_ff <= valid_q[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            hue_acc_ff <= hue_acc_in;
            sat_acc_ff <= sat_acc_in;
            hue_div_ff <= hue_div_q[k];
            sat_div_ff <= sat_div_q[k];
            info_ff    <= info_q[k];
         end
      end

      assign valid_q[k+1]   = valid_ff;
      assign hue_acc_q[k+1] = hue_acc_ff;
      assign sat_acc_q[k+1] = sat_acc_ff;
      assign hue_div_q[k+1] = hue_div_ff;
      assign sat_div_q[k+1] = sat_div_ff;
      assign info_q[k+1]    = info_ff;
   end

   assign out_valid   = valid_q[QUO_W];
   assign out_hue_quo = hue_acc_q[QUO_W][QUO_W-1:0];
   assign out_sat_quo = sat_acc_q[QUO_W][QUO_W-1:0];
   assign out_info    = info_q[QUO_W];

endmodule

`default_nettype wire

[hdl/rgb_to_hsv_converter.sv]
// Converts one ARGB pixel per clock into hue, saturation and value (alpha is
// dropped). Hue comes in 1/2^HUE_FRAC_BITS degree steps, floored, 0 when the
// pixel is grey; saturation is floor(255*delta/max), 0 for black; brightness is
// the largest channel. A new pixel is taken every cycle unless a stalled
// result has backed the pipeline up to its input; a pixel passes through
// max(HUE_FRAC_BITS+6, 8) + 3 register stages: two front-end stages, one stage
// per quotient bit of the pipelined hue and saturation dividers, and the output
// register. The transfer edge loads the first stage. A stalled result backs up
// the pipeline only as far as it is full.
// depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_divider
`default_nettype none

module rgb_to_hsv_converter #(
   parameter int HUE_FRAC_BITS = 6
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [rgbhsv_pkg::PIXEL_W-1:0]   req_argb_pixel,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [rgbhsv_pkg::HUE_W-1:0]          rsp_hue,
   output logic [rgbhsv_pkg::SAT_W-1:0]          rsp_saturation,
   output logic [rgbhsv_pkg::CHAN_W-1:0]         rsp_brightness
);
   import rgbhsv_pkg::*;

   localparam int HUE_QUO_W   = HUE_FRAC_BITS + 6;
   localparam int QUO_W       = (HUE_QUO_W > SAT_W) ? HUE_QUO_W : SAT_W;
   localparam int ACC_W       = CHAN_W + QUO_W;
   localparam int HUE_FULL_W  = HUE_FRAC_BITS + 9;
   localparam int SECTOR_STEP = SECTOR_DEG << HUE_FRAC_BITS;

   logic               fr_valid, fr_ready;
   logic [ACC_W-1:0]   fr_hue_acc, fr_sat_acc;
   logic [CHAN_W-1:0]  fr_hue_div, fr_sat_div;
   pix_info_type       fr_info;

   logic               dv_valid, dv_ready;
   logic [QUO_W-1:0]   dv_hue_quo, dv_sat_quo;
   pix_info_type       dv_info;

   logic               rsp_valid_ff;
   logic [HUE_W-1:0]   rsp_hue_ff, rsp_hue_in;
   logic [SAT_W-1:0]   rsp_sat_ff, rsp_sat_in;
   logic [CHAN_W-1:0]  rsp_val_ff;
   logic [HUE_FULL_W-1:0] hue_full;
   logic [2:0]         sector_code;

   rgbhsv_front #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .QUO_W         (QUO_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_pixel    (req_argb_pixel),
      .out_valid   (fr_valid),
      .out_ready   (fr_ready),
      .out_hue_acc (fr_hue_acc),
      .out_sat_acc (fr_sat_acc),
      .out_hue_div (fr_hue_div),
      .out_sat_div (fr_sat_div),
      .out_info    (fr_info)
   );

   rgbhsv_divider #(
      .QUO_W (QUO_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (fr_valid),
      .in_ready    (fr_ready),
      .in_hue_acc  (fr_hue_acc),
      .in_sat_acc  (fr_sat_acc),
      .in_hue_div  (fr_hue_div),
      .in_sat_div  (fr_sat_div),
      .in_info     (fr_info),
      .out_valid   (dv_valid),
      .out_ready   (dv_ready),
      .out_hue_quo (dv_hue_quo),
      .out_sat_quo (dv_sat_quo),
      .out_info    (dv_info)
   );

   assign dv_ready = !rsp_valid_ff || rsp_ready;

   // hue = sector base plus the scaled in-sector fraction, kept to the port width
   assign sector_code = dv_info.sector;
   assign hue_full    = HUE_FULL_W'(sector_code) * HUE_FULL_W'(SECTOR_STEP)
                      + HUE_FULL_W'(dv_hue_quo);
   assign rsp_hue_in  = dv_info.grey  ? '0 : HUE_W'(hue_full);
   assign rsp_sat_in  = dv_info.black ? '0 : dv_sat_quo[SAT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dv_ready) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ready) begin
         rsp_hue_ff <= rsp_hue_in;
         rsp_sat_ff <= rsp_sat_in;
         rsp_val_ff <= dv_info.brightness;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = rsp_hue_ff;
   assign rsp_saturation = rsp_sat_ff;
   assign rsp_brightness = rsp_val_ff;

endmodule

`default_nettype wire

[hdl/rgbhsv_checker.sv]
// port-level checks for rgb_to_hsv_converter, attached by bind
// depends on rgb_to_hsv_converter_defines.svh
`default_nettype none

`include "rgb_to_hsv_converter_defines.svh"

module rgbhsv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [14:0] rsp_hue,
   input wire logic [7:0]  rsp_saturation,
   input wire logic [7:0]  rsp_brightness
);

   // a stalled result stays put
   `RGBHSV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_hue, rsp_saturation, rsp_brightness}))

   // with the output register empty the whole pipeline can move
   `RGBHSV_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // black pixel has no saturation
   `RGBHSV_ASSERT_NOW(a_black_no_sat, clock, reset, rsp_valid && rsp_brightness == 8'd0, rsp_saturation == 8'd0)

   // zero saturation only happens for grey, which has hue zero
   `RGBHSV_ASSERT_NOW(a_grey_no_hue, clock, reset, rsp_valid && rsp_saturation == 8'd0, rsp_hue == 15'd0)

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_rgbhsv_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation),
   .rsp_brightness (rsp_brightness)
);

`default_nettype wire

[bench/tb.sv]
// self-checking bench for rgb_to_hsv_converter: pixel driver, hsv predictor and output checker
// depends on rgbhsv_pkg and rgb_to_hsv_converter
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rgbhsv_pkg::*;

   localparam int FRAC_BITS    = 6;
   localparam int LATENCY      = ((FRAC_BITS + 6 > 8) ? FRAC_BITS + 6 : 8) + 3;
   localparam int RANDOM_ITEMS = 530;
   localparam int CALM_FROM    = 120;
   localparam int CALM_TO      = 220;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 80;
   localparam int PUSH_TO      = 400;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [SAT_W-1:0]  saturation;
      logic [CHAN_W-1:0] brightness;
   } hsv_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [PIXEL_W-1:0]  req_argb_pixel = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [HUE_W-1:0]    rsp_hue;
   logic [SAT_W-1:0]    rsp_saturation;
   logic [CHAN_W-1:0]   rsp_brightness;

   logic [PIXEL_W-1:0]  pixel_q[$];
   hsv_type             hsv_expected_q[$];
   bit                  req_xfer = 1'b0;
   int                  pixels_taken = 0;
   int                  pixels_checked = 0;
   int                  input_stall_cycles = 0;
   int                  directed_count = 0;
   int                  fail_count = 0;
   int                  hold_left = 0;
   bit                  hold_done = 1'b0;

   rgb_to_hsv_converter #(
      .HUE_FRAC_BITS(FRAC_BITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_argb_pixel (req_argb_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      fail_count++;
   endtask

   // exact hexcone conversion, floors only, alpha dropped
   function automatic hsv_type hsv_of(input logic [PIXEL_W-1:0] pixel);
      longint unsigned r, g, b, mx, mn, delta, num, hue;
      hsv_type res;
      r  = 64'(pixel[23:16]);
      g  = 64'(pixel[15:8]);
      b  = 64'(pixel[7:0]);
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      if (delta == 0) begin
         hue = 0;
      end else begin
         if (mx == r) begin
            if (g >= b) num = 60 * (g - b);
            else num = 360 * delta - 60 * (b - g);
         end else if (mx == g) begin
            num = 120 * delta + 60 * b - 60 * r;
         end else begin
            num = 240 * delta + 60 * r - 60 * g;
         end
         hue = (num << FRAC_BITS) / delta;
      end
      res.hue        = hue[HUE_W-1:0];
      res.saturation = (mx == 0) ? '0 : SAT_W'((255 * delta) / mx);
      res.brightness = mx[CHAN_W-1:0];
      return res;
   endfunction

   // channel bytes biased toward extremes and ties
   function automatic logic [PIXEL_W-1:0] random_pixel();
      logic [CHAN_W-1:0] r, g, b;
      logic [PIXEL_W-1:0] px;
      px = $urandom;
      if ($urandom_range(0, 99) < 50) return px;
      r = px[23:16];
      g = px[15:8];
      b = px[7:0];
      case ($urandom_range(0, 5))
         0: r = 8'hFF;
         1: g = r;
         2: b = g;
         3: b = r;
         4: begin
            r = CHAN_W'($urandom_range(0, 3));
            g = CHAN_W'($urandom_range(0, 3));
            b = CHAN_W'($urandom_range(0, 3));
         end
         default: begin
            g = r - CHAN_W'($urandom_range(0, 2));
            b = r - CHAN_W'($urandom_range(0, 2));
         end
      endcase
      return {px[31:24], r, g, b};
   endfunction

   // driver: offers the next pending pixel once the slot is free, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_xfer) begin
         if (pixel_q.size() != 0 &&
             ((pixels_taken >= CALM_FROM && pixels_taken < CALM_TO) ||
              (pixels_taken >= HOLD_AT && pixels_taken < PUSH_TO) ||
              $urandom_range(0, 99) >= 20)) begin
            req_valid      <= 1'b1;
            req_argb_pixel <= pixel_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random backpressure plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (!hold_done && pixels_taken >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (pixels_taken >= CALM_FROM && pixels_taken < CALM_TO) ||
                      $urandom_range(0, 99) >= 20;
      end
   end

   // monitor: predict on input transfer, check on output transfer
   always @(posedge clock) begin
      hsv_type want;
      req_xfer = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_xfer = 1'b1;
            hsv_expected_q.push_back(hsv_of(req_argb_pixel));
            pixels_taken++;
         end
         if (req_valid && !req_ready) input_stall_cycles++;
         if (rsp_valid && rsp_ready) begin
            if (hsv_expected_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result hue=%0d sat=%0d val=%0d",
                                         rsp_hue, rsp_saturation, rsp_brightness));
            end else begin
               want = hsv_expected_q.pop_front();
               if (rsp_hue !== want.hue)
                  report_mismatch($sformatf("result %0d hue %0d, expected %0d",
                                            pixels_checked, rsp_hue, want.hue));
               if (rsp_saturation !== want.saturation)
                  report_mismatch($sformatf("result %0d saturation %0d, expected %0d",
                                            pixels_checked, rsp_saturation,
                                            want.saturation));
               if (rsp_brightness !== want.brightness)
                  report_mismatch($sformatf("result %0d brightness %0d, expected %0d",
                                            pixels_checked, rsp_brightness,
                                            want.brightness));
            end
            pixels_checked++;
         end
      end
   end

   initial begin
      // black, white, greys, primaries, ties, red wrap, tiny deltas, alpha noise
      pixel_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h7F80_8080,
                  32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'h00FF_FF00,
                  32'h00FF_00FF, 32'h0000_FFFF, 32'h00FF_0010, 32'h00FF_1000,
                  32'h0001_0000, 32'h00FE_0001, 32'hAA12_3456, 32'h8001_0203,
                  32'h80FF_0001, 32'h5510_FF20, 32'h0020_40FF, 32'hFF01_0101,
                  32'h0001_0001, 32'h00FF_FEFF};
      directed_count = pixel_q.size();
      repeat (RANDOM_ITEMS) pixel_q.push_back(random_pixel());
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pixel_q.size() != 0 || req_valid) @(posedge clock);
      while (hsv_expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (hsv_expected_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", hsv_expected_q.size()));
      $display("covered %0d directed and %0d random pixels, %0d results checked",
               directed_count, RANDOM_ITEMS, pixels_checked);
      $display("input side stalled %0d cycles, one %0d-cycle output hold-off",
               input_stall_cycles, HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #400us;
      $display("timeout after %0d of %0d pixels checked", pixels_checked,
               directed_count + RANDOM_ITEMS);
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
